>>> hw/rtl/smpq_pkg.sv
// shared constants, codes and types of the stable minimum priority queue
package smpq_pkg;

    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int RANK_W   = 16;
    localparam int TAG_W    = 32;
    localparam int FUNC_W   = 2;
    localparam int STAT_W   = 2;
    localparam int ECNT_W   = 5;

    localparam logic [FUNC_W-1:0] FUNC_PEEK = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_PUSH = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_POP  = 2'd2;

    localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

    // operation broadcast to every cell
    typedef struct packed {
        logic              push;
        logic              pop;
        logic [RANK_W-1:0] rank;
        logic [TAG_W-1:0]  tag;
    } cell_ctl_t;

    // what a cell shows its neighbors
    typedef struct packed {
        logic              occ;
        logic              le;
        logic [RANK_W-1:0] rank;
        logic [TAG_W-1:0]  tag;
    } cell_link_t;

endpackage

>>> hw/rtl/smpq_cell.sv
// one slot of the sorted queue: holds an entry, shifts up on push and down on pop
module smpq_cell (
    input  logic                aclk,
    input  logic                aresetn,
    input  smpq_pkg::cell_ctl_t  ctl,
    input  smpq_pkg::cell_link_t prev_link,
    input  smpq_pkg::cell_link_t next_link,
    output smpq_pkg::cell_link_t self_link
);

    logic                        occ_reg;
    logic                        occ_next;
    logic [smpq_pkg::RANK_W-1:0] rank_reg;
    logic [smpq_pkg::RANK_W-1:0] rank_next;
    logic [smpq_pkg::TAG_W-1:0]  tag_reg;
    logic [smpq_pkg::TAG_W-1:0]  tag_next;
    logic                        le;

    // entry stays ahead of a new one of equal rank
    assign le = occ_reg && (rank_reg <= ctl.rank);

    always_comb begin
        occ_next  = occ_reg;
        rank_next = rank_reg;
        tag_next  = tag_reg;
        if (ctl.push) begin
            occ_next = occ_reg | prev_link.occ;
            if (!le) begin
                if (!prev_link.le) begin
                    rank_next = prev_link.rank;
                    tag_next  = prev_link.tag;
                end else begin
                    rank_next = ctl.rank;
                    tag_next  = ctl.tag;
                end
            end
        end else if (ctl.pop) begin
            occ_next  = next_link.occ;
            rank_next = next_link.rank;
            tag_next  = next_link.tag;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg <= 1'b0;
        end else begin
            occ_reg <= occ_next;
        end
        rank_reg <= rank_next;
        tag_reg  <= tag_next;
    end

    assign self_link.occ  = occ_reg;
    assign self_link.le   = le;
    assign self_link.rank = rank_reg;
    assign self_link.tag  = tag_reg;

endmodule

>>> hw/rtl/stable_min_priority_queue.sv
// top level of the stable minimum priority queue built as a chain of slot cells
//
// usage:
//   input channel s_axis: each transfer is one operation. s_tuser carries the
//   operation (peek, push, pop); s_tdata carries the rank and tag of a push,
//   ignored for peek and pop.
//   result channel m_axis: exactly one transfer per operation, describing the
//   queue after it: head rank and tag (zero when empty), empty and full flags,
//   entry count and status (done, push refused because full, pop on empty).
//   latency: the result is valid in the cycle after the input transfer.
//   throughput: one operation per cycle while results are drained; every slot
//   cell compares its rank with the incoming one in parallel and shifts by one place.
//   the result is read straight from the head cell and the count register,
//   so a new operation is taken whenever the result slot is empty or being
//   drained in the same cycle.
//   reset: the queue empties (all occupancy bits and the count clear) and no
//   result is pending. slot contents are not cleared.
//   receiver stall: with m_tready low and a result pending, s_tready drops
//   and the queue holds its state until the result transfer completes.
module stable_min_priority_queue (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // rank [15:0], tag [47:16]
    input  logic [1:0]  s_tuser,   // func [1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata    // head_rank [15:0], head_tag [47:16], is_empty [48],
                                   // is_full [49], entry_count [54:50], status [56:55]
);

    localparam int CAP = smpq_pkg::CAPACITY;

    logic                        accept;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic [smpq_pkg::CNT_W-1:0]  count_reg;
    logic [smpq_pkg::CNT_W-1:0]  count_next;
    logic [smpq_pkg::STAT_W-1:0] status_reg;
    logic [smpq_pkg::STAT_W-1:0] status_next;
    logic [smpq_pkg::FUNC_W-1:0] func;
    logic                        is_full;
    logic                        is_empty;
    logic [smpq_pkg::RANK_W-1:0] head_rank;
    logic [smpq_pkg::TAG_W-1:0]  head_tag;
    logic [CAP-1:0]              occ_vec;

    smpq_pkg::cell_ctl_t  ctl;
    smpq_pkg::cell_link_t links [CAP];
    smpq_pkg::cell_link_t prev_links [CAP];
    smpq_pkg::cell_link_t next_links [CAP];

    assign accept   = s_tvalid && s_tready;
    assign s_tready = !out_valid_reg || m_tready;
    assign func     = s_tuser;

    assign is_full  = (count_reg == smpq_pkg::CNT_W'(CAP));
    assign is_empty = (count_reg == '0);

    // operation decode with full and empty refusal
    always_comb begin
        ctl.push    = 1'b0;
        ctl.pop     = 1'b0;
        ctl.rank    = s_tdata[15:0];
        ctl.tag     = s_tdata[47:16];
        count_next  = count_reg;
        status_next = status_reg;
        if (accept) begin
            status_next = smpq_pkg::STAT_DONE;
            case (func)
                smpq_pkg::FUNC_PUSH: begin
                    if (is_full) begin
                        status_next = smpq_pkg::STAT_FULL;
                    end else begin
                        ctl.push   = 1'b1;
                        count_next = count_reg + smpq_pkg::CNT_W'(1);
                    end
                end
                smpq_pkg::FUNC_POP: begin
                    if (is_empty) begin
                        status_next = smpq_pkg::STAT_EMPTY;
                    end else begin
                        ctl.pop    = 1'b1;
                        count_next = count_reg - smpq_pkg::CNT_W'(1);
                    end
                end
                default: begin
                    // peek and the unused code leave the queue unchanged and report done
                end
            endcase
        end
    end

    // neighbor wiring: the head sees an always-open insertion point before it,
    // the tail sees an empty slot after it
    always_comb begin
        for (int i = 0; i < CAP; i++) begin
            if (i == 0) begin
                prev_links[i].occ  = 1'b1;
                prev_links[i].le   = 1'b1;
                prev_links[i].rank = '0;
                prev_links[i].tag  = '0;
            end else begin
                prev_links[i] = links[i-1];
            end
            if (i == CAP - 1) begin
                next_links[i].occ  = 1'b0;
                next_links[i].le   = 1'b0;
                next_links[i].rank = '0;
                next_links[i].tag  = '0;
            end else begin
                next_links[i] = links[i+1];
            end
            occ_vec[i] = links[i].occ;
        end
    end

    for (genvar g = 0; g < CAP; g++) begin : g_cell
        smpq_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctl       (ctl),
            .prev_link (prev_links[g]),
            .next_link (next_links[g]),
            .self_link (links[g])
        );
    end

    // a result is pending from the transfer in until the transfer out
    always_comb begin
        out_valid_next = out_valid_reg;
        if (accept) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
            status_reg    <= smpq_pkg::STAT_DONE;
        end else begin
            out_valid_reg <= out_valid_next;
            count_reg     <= count_next;
            status_reg    <= status_next;
        end
    end

    // result taken live from the head cell; state only moves on an input transfer
    assign head_rank = is_empty ? '0 : links[0].rank;
    assign head_tag  = is_empty ? '0 : links[0].tag;

    assign m_tvalid       = out_valid_reg;
    assign m_tdata[15:0]  = head_rank;
    assign m_tdata[47:16] = head_tag;
    assign m_tdata[48]    = is_empty;
    assign m_tdata[49]    = is_full;
    assign m_tdata[54:50] = smpq_pkg::ECNT_W'(count_reg);
    assign m_tdata[56:55] = status_reg;
    assign m_tdata[63:57] = '0;

`ifndef SYNTHESIS
    // occupancy of the head cell tracks the count
    a_head_occ: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0) == !links[0].occ)
        else $error("head occupancy disagrees with count");

    // the number of occupied cells equals the count
    a_occ_count: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(occ_vec) == int'(count_reg))
        else $error("occupied cells disagree with count");

    // a refused push leaves the count alone
    a_full_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && func == smpq_pkg::FUNC_PUSH && is_full |=>
        status_reg == smpq_pkg::STAT_FULL && $stable(count_reg))
        else $error("refused push changed the queue");

    // head is never ranked above its successor
    a_sorted: assert property (@(posedge aclk) disable iff (!aresetn)
        links[1].occ |-> links[0].rank <= links[1].rank)
        else $error("head out of order");
`endif

endmodule
